// ===== hdl/qgsv_pkg.sv =====
// ----------------------------------------------------------------------------
// qgsv_pkg
// Shared types and constants of the state-vector gate engine.
// ----------------------------------------------------------------------------
`default_nettype none

package qgsv_pkg;

    // Request kinds.
    typedef enum logic [1:0] {
        REQ_LOAD_AMP = 2'd0,
        REQ_LOAD_MAT = 2'd1,
        REQ_APPLY    = 2'd2,
        REQ_READ_AMP = 2'd3
    } t_req;

    // Result status codes.
    localparam logic [1:0] ST_OK        = 2'd0;
    localparam logic [1:0] ST_BAD_QUBIT = 2'd1;
    localparam logic [1:0] ST_BAD_INDEX = 2'd2;

    localparam int GATE_MAX  = 3;
    localparam int MAT_DEPTH = 64;

    // Input request payload.
    typedef struct packed {
        logic [1:0]         req_type;
        logic [9:0]         index;
        logic signed [31:0] value_re;
        logic signed [31:0] value_im;
        logic [1:0]         gate_qubits;
        logic [3:0]         qubit_a;
        logic [3:0]         qubit_b;
        logic [3:0]         qubit_c;
    } t_in;

    // Result payload.
    typedef struct packed {
        logic signed [31:0] amp_re;
        logic signed [31:0] amp_im;
        logic [1:0]         status;
    } t_out;

    // Classified command handed from the front part to the back part.
    typedef struct packed {
        t_req        kind;
        logic        err;       // request fails, report status only
        logic [1:0]  status;
        logic [9:0]  index;
        logic [63:0] value;     // imaginary in high half
        logic [1:0]  gq;
        logic [3:0]  qa;
        logic [3:0]  qb;
        logic [3:0]  qc;
        logic [4:0]  len_log;   // effective qubit count
    } t_cmd;

    // Rounded Q2.30 product, round half up.
    function automatic logic signed [33:0] rmul(input logic signed [31:0] a,
                                                input logic signed [31:0] b);
        logic signed [63:0] p;
        logic signed [63:0] s;
        begin
            p = a * b;
            s = p + 64'sd536870912;
            rmul = s[63:30];
        end
    endfunction

endpackage

`default_nettype wire

// ===== hdl/qgsv_if.sv =====
// ----------------------------------------------------------------------------
// qgsv_if
// Valid/ready channel carrying one payload of a generic type.
// ----------------------------------------------------------------------------
`default_nettype none

interface qgsv_if #(parameter type T = logic);
    logic valid;
    logic ready;
    T     data;
    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

`default_nettype wire

// ===== hdl/qubit_gate_state_vector_apply.sv =====
// Loads, matrix loads and reads pass through the S_RDW and S_OUT states before
// their result is registered; the back end takes a new request only when idle
// and its last result has been taken. A gate apply runs a multiply-accumulate
// sweep into scratch RAM, reading one amplitude per pattern through the single
// amplitude RAM read port, then copies scratch back. A two-entry command queue
// lets requests be taken while the back end works.
// Reset is synchronous, active low; qubit_count resets to 10, memories are not cleared.
// ----------------------------------------------------------------------------
// qubit_gate_state_vector_apply
// State-vector engine that loads amplitudes and applies 1- to 3-qubit gates.
// ----------------------------------------------------------------------------
`default_nettype none

module qubit_gate_state_vector_apply
    import qgsv_pkg::*;
#(
    parameter int MAX_QUBITS = 10
) (
    input  wire logic       i_clk,
    input  wire logic       i_rst_n,
    input  wire logic       i_cfg_we,
    input  wire logic [3:0] i_cfg_wdata,
    qgsv_if.sink            s_in,
    qgsv_if.source          m_out
);
    logic [3:0] r_qubit_count;
    logic       w_busy;

    qgsv_if #(.T(t_cmd)) cmd_if ();

    // Configuration register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r_qubit_count <= 4'd10;
        else if (i_cfg_we) r_qubit_count <= i_cfg_wdata;
    end

    qgsv_front #(.MAX_QUBITS(MAX_QUBITS)) u_front (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_qubit_count(r_qubit_count),
        .s_in(s_in), .m_cmd(cmd_if.source));

    qgsv_back #(.MAX_QUBITS(MAX_QUBITS)) u_back (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .s_cmd(cmd_if.sink),
        .m_out(m_out), .o_busy(w_busy));

    // A result never carries both an error status and read data.
    a_err_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (m_out.valid && m_out.data.status != ST_OK) |->
        (m_out.data.amp_re == '0 && m_out.data.amp_im == '0))
        else $error("error result with data");

    // The back end only takes a command when idle.
    a_take_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (cmd_if.valid && cmd_if.ready) |-> !w_busy)
        else $error("command taken while busy");

    // A waiting result holds until it is taken.
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (m_out.valid && !m_out.ready) |=> (m_out.valid && $stable(m_out.data)))
        else $error("result changed while waiting");
endmodule

`default_nettype wire

// ===== hdl/qgsv_ram.sv =====
// ----------------------------------------------------------------------------
// qgsv_ram
// Single-port-write, single-port-read RAM with registered read data.
// ----------------------------------------------------------------------------
`default_nettype none

module qgsv_ram #(
    parameter int WIDTH = 64,
    parameter int DEPTH = 1024
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_we,
    input  wire logic [$clog2(DEPTH)-1:0] i_waddr,
    input  wire logic [WIDTH-1:0]         i_wdata,
    input  wire logic [$clog2(DEPTH)-1:0] i_raddr,
    output      logic [WIDTH-1:0]         o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];

    // Write port and registered read port.
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        o_rdata <= r_mem[i_raddr];
    end
endmodule

`default_nettype wire

// ===== hdl/qgsv_front.sv =====
// ----------------------------------------------------------------------------
// qgsv_front
// Accepts requests, checks ranges and queues classified commands.
// ----------------------------------------------------------------------------
`default_nettype none

module qgsv_front
    import qgsv_pkg::*;
#(
    parameter int MAX_QUBITS = 10
) (
    input  wire logic i_clk,
    input  wire logic i_rst_n,
    input  wire logic [3:0] i_qubit_count,
    qgsv_if.sink   s_in,
    qgsv_if.source m_cmd
);
    localparam int QD = 2;

    t_cmd       r_q [QD];
    logic [1:0] r_cnt;
    logic       r_rd, r_wr;
    t_cmd       w_cmd;
    logic [4:0] w_eff;
    logic [20:0] w_len;
    logic       w_push, w_pop;

    // Classify the incoming request.
    always_comb begin
        w_eff = ({1'b0, i_qubit_count} > 5'(MAX_QUBITS)) ? 5'(MAX_QUBITS)
                                                         : {1'b0, i_qubit_count};
        w_len = 21'd1 << w_eff;
        w_cmd = '0;
        w_cmd.kind    = t_req'(s_in.data.req_type);
        w_cmd.index   = s_in.data.index;
        w_cmd.value   = {s_in.data.value_im, s_in.data.value_re};
        w_cmd.gq      = s_in.data.gate_qubits;
        w_cmd.qa      = s_in.data.qubit_a;
        w_cmd.qb      = s_in.data.qubit_b;
        w_cmd.qc      = s_in.data.qubit_c;
        w_cmd.len_log = w_eff;
        w_cmd.status  = ST_OK;
        case (t_req'(s_in.data.req_type))
            REQ_LOAD_AMP, REQ_READ_AMP: begin
                if ({11'd0, s_in.data.index} >= w_len) begin
                    w_cmd.err = 1'b1;
                    w_cmd.status = ST_BAD_INDEX;
                end
            end
            REQ_LOAD_MAT: begin
                if ({1'b0, s_in.data.index} >= 11'(MAT_DEPTH)) begin
                    w_cmd.err = 1'b1;
                    w_cmd.status = ST_BAD_INDEX;
                end
            end
            default: begin
                if (s_in.data.gate_qubits == 2'd0 ||
                    {1'b0, s_in.data.qubit_a} >= w_eff ||
                    (s_in.data.gate_qubits >= 2'd2 && {1'b0, s_in.data.qubit_b} >= w_eff) ||
                    (s_in.data.gate_qubits == 2'd3 && {1'b0, s_in.data.qubit_c} >= w_eff)) begin
                    w_cmd.err = 1'b1;
                    w_cmd.status = ST_BAD_QUBIT;
                end
            end
        endcase
    end

    assign s_in.ready  = (r_cnt != 2'd2);
    assign m_cmd.valid = (r_cnt != 2'd0);
    assign m_cmd.data  = r_q[r_rd];
    assign w_push = s_in.valid && s_in.ready;
    assign w_pop  = m_cmd.valid && m_cmd.ready;

    // Two-entry command queue.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt <= '0;
            r_rd  <= 1'b0;
            r_wr  <= 1'b0;
        end else begin
            if (w_push) r_wr <= ~r_wr;
            if (w_pop)  r_rd <= ~r_rd;
            r_cnt <= r_cnt + 2'(w_push) - 2'(w_pop);
        end
        if (w_push) r_q[r_wr] <= w_cmd;
    end
endmodule

`default_nettype wire

// ===== hdl/qgsv_back.sv =====
// ----------------------------------------------------------------------------
// qgsv_back
// Executes commands: loads, reads and the sweep that applies a gate.
// ----------------------------------------------------------------------------
`default_nettype none

module qgsv_back
    import qgsv_pkg::*;
#(
    parameter int MAX_QUBITS = 10
) (
    input  wire logic i_clk,
    input  wire logic i_rst_n,
    qgsv_if.sink   s_cmd,
    qgsv_if.source m_out,
    output      logic o_busy
);
    localparam int AW    = MAX_QUBITS;
    localparam int DEPTH = 1 << MAX_QUBITS;

    typedef enum logic [5:0] {
        S_IDLE  = 6'b000001,
        S_RDW   = 6'b000010,
        S_MAC   = 6'b000100,
        S_COPY  = 6'b001000,
        S_COPYW = 6'b010000,
        S_OUT   = 6'b100000
    } t_state;

    t_state r_st;
    t_cmd   r_cmd;
    t_out   r_res;
    logic   r_ovalid;
    logic [AW:0] r_i, r_ci;     // sweep counters, one extra bit for the end
    logic [3:0]  r_p;           // pattern issue counter
    logic [3:0]  r_pa;          // accumulate counter
    logic        r_rv;          // read data valid this cycle
    logic signed [41:0] r_sre, r_sim;
    logic signed [33:0] r_t0, r_t1, r_t2, r_t3;
    logic        r_tv;

    logic [AW-1:0] w_a_raddr, w_a_waddr, w_s_waddr, w_s_raddr;
    logic [63:0]   w_a_rdata, w_a_wdata, w_s_rdata, w_s_wdata;
    logic [5:0]    w_m_raddr, w_m_waddr;
    logic [63:0]   w_m_rdata;
    logic          w_a_we, w_s_we, w_m_we;
    logic [3:0]    w_dim;
    logic [AW-1:0] w_src, w_iv;
    logic [2:0]    w_row;
    logic [AW:0]   w_len;
    logic          w_take;

    qgsv_ram #(.WIDTH(64), .DEPTH(DEPTH)) u_amp (
        .i_clk(i_clk), .i_we(w_a_we), .i_waddr(w_a_waddr), .i_wdata(w_a_wdata),
        .i_raddr(w_a_raddr), .o_rdata(w_a_rdata));
    qgsv_ram #(.WIDTH(64), .DEPTH(DEPTH)) u_scr (
        .i_clk(i_clk), .i_we(w_s_we), .i_waddr(w_s_waddr), .i_wdata(w_s_wdata),
        .i_raddr(w_s_raddr), .o_rdata(w_s_rdata));
    qgsv_ram #(.WIDTH(64), .DEPTH(MAT_DEPTH)) u_mat (
        .i_clk(i_clk), .i_we(w_m_we), .i_waddr(w_m_waddr), .i_wdata(r_cmd.value),
        .i_raddr(w_m_raddr), .o_rdata(w_m_rdata));

    // Index helpers for the gate sweep.
    function automatic logic [AW-1:0] set_q(input logic [AW-1:0] v,
                                            input logic [3:0] q, input logic b);
        logic [AW-1:0] m;
        begin
            m = AW'(1) << q;
            set_q = b ? (v | m) : (v & ~m);
        end
    endfunction

    function automatic logic bit_at(input logic [AW-1:0] v, input logic [3:0] q);
        logic [AW-1:0] s;
        begin
            s = v >> q;
            bit_at = s[0];
        end
    endfunction

    assign w_iv  = r_i[AW-1:0];
    assign w_dim = 4'd1 << r_cmd.gq;
    assign w_len = (AW+1)'(1) << r_cmd.len_log;

    // Source address and matrix row for the current pattern.
    always_comb begin
        w_src = w_iv;
        w_row = '0;
        case (r_cmd.gq)
            2'd1: begin
                w_src = set_q(w_src, r_cmd.qa, r_p[0]);
                w_row = {2'b0, bit_at(w_iv, r_cmd.qa)};
            end
            2'd2: begin
                w_src = set_q(w_src, r_cmd.qa, r_p[1]);
                w_src = set_q(w_src, r_cmd.qb, r_p[0]);
                w_row = {1'b0, bit_at(w_iv, r_cmd.qa), bit_at(w_iv, r_cmd.qb)};
            end
            default: begin
                w_src = set_q(w_src, r_cmd.qa, r_p[2]);
                w_src = set_q(w_src, r_cmd.qb, r_p[1]);
                w_src = set_q(w_src, r_cmd.qc, r_p[0]);
                w_row = {bit_at(w_iv, r_cmd.qa), bit_at(w_iv, r_cmd.qb),
                         bit_at(w_iv, r_cmd.qc)};
            end
        endcase
    end

    // Memory port steering.
    always_comb begin
        w_a_we    = 1'b0;
        w_a_waddr = AW'(r_cmd.index);
        w_a_wdata = r_cmd.value;
        w_a_raddr = AW'(r_cmd.index);
        w_m_we    = 1'b0;
        w_m_waddr = r_cmd.index[5:0];
        w_m_raddr = 6'((7'(w_row) * 7'(w_dim)) + 7'(r_p));
        w_s_we    = 1'b0;
        w_s_waddr = r_ci[AW-1:0];
        w_s_wdata = '0;
        w_s_raddr = r_i[AW-1:0];
        if (r_st == S_IDLE && s_cmd.valid && !r_ovalid && !s_cmd.data.err) begin
            w_a_raddr = AW'(s_cmd.data.index);
        end
        if (r_st == S_MAC) w_a_raddr = w_src;
        if (r_st == S_OUT && !r_cmd.err) begin
            w_a_we = (r_cmd.kind == REQ_LOAD_AMP);
            w_m_we = (r_cmd.kind == REQ_LOAD_MAT);
        end
        if (r_st == S_MAC && r_pa == w_dim && r_tv == 1'b0 && r_rv == 1'b0) begin
            w_s_we = 1'b1;
            w_s_waddr = w_iv;
            w_s_wdata = {(r_sim > 42'sd2147483647) ? 32'h7fffffff :
                         (r_sim < -42'sd2147483648) ? 32'h80000000 : r_sim[31:0],
                         (r_sre > 42'sd2147483647) ? 32'h7fffffff :
                         (r_sre < -42'sd2147483648) ? 32'h80000000 : r_sre[31:0]};
        end
        if (r_st == S_COPYW) begin
            w_a_we = 1'b1;
            w_a_waddr = r_ci[AW-1:0];
            w_a_wdata = w_s_rdata;
        end
    end

    assign s_cmd.ready = (r_st == S_IDLE) && !r_ovalid;
    assign w_take      = s_cmd.valid && s_cmd.ready;
    assign m_out.valid = r_ovalid;
    assign m_out.data  = r_res;
    assign o_busy      = (r_st != S_IDLE);

    // Sequencer and multiply-accumulate datapath.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_st     <= S_IDLE;
            r_ovalid <= 1'b0;
        end else begin
            if (m_out.valid && m_out.ready) r_ovalid <= 1'b0;
            case (r_st)
                S_IDLE: begin
                    if (w_take) begin
                        r_cmd <= s_cmd.data;
                        r_i   <= '0;
                        r_p   <= '0;
                        r_pa  <= '0;
                        r_rv  <= 1'b0;
                        r_tv  <= 1'b0;
                        r_sre <= '0;
                        r_sim <= '0;
                        r_st  <= (s_cmd.data.kind == REQ_APPLY && !s_cmd.data.err) ?
                                 S_MAC : S_RDW;
                    end
                end
                S_RDW: r_st <= S_OUT;
                S_MAC: begin
                    // Issue reads, then register products, then accumulate.
                    r_rv <= (r_p < w_dim);
                    if (r_p < w_dim) r_p <= r_p + 4'd1;
                    r_tv <= r_rv;
                    if (r_rv) begin
                        r_t0 <= rmul(w_m_rdata[31:0], w_a_rdata[31:0]);
                        r_t1 <= rmul(w_m_rdata[63:32], w_a_rdata[63:32]);
                        r_t2 <= rmul(w_m_rdata[31:0], w_a_rdata[63:32]);
                        r_t3 <= rmul(w_m_rdata[63:32], w_a_rdata[31:0]);
                    end
                    if (r_tv) begin
                        r_sre <= r_sre + 42'(r_t0) - 42'(r_t1);
                        r_sim <= r_sim + 42'(r_t2) + 42'(r_t3);
                        r_pa  <= r_pa + 4'd1;
                    end
                    // The copy-back starts reading scratch at entry zero.
                    if (w_s_we) begin
                        r_sre <= '0;
                        r_sim <= '0;
                        r_p   <= '0;
                        r_pa  <= '0;
                        if (r_i + 1'b1 == w_len) begin
                            r_i  <= '0;
                            r_ci <= '0;
                            r_st <= S_COPY;
                        end else begin
                            r_i  <= r_i + 1'b1;
                        end
                    end
                end
                S_COPY: begin
                    // Scratch read address follows r_i, set it to copy index.
                    r_i  <= r_ci;
                    r_st <= S_COPYW;
                end
                S_COPYW: begin
                    r_ci <= r_ci + 1'b1;
                    r_i  <= r_ci + 1'b1;
                    r_st <= (r_ci + 1'b1 == w_len) ? S_OUT : S_COPY;
                end
                S_OUT: begin
                    if (!r_ovalid) begin
                        r_res.status <= r_cmd.status;
                        r_res.amp_re <= (r_cmd.kind == REQ_READ_AMP && !r_cmd.err) ?
                                        w_a_rdata[31:0] : '0;
                        r_res.amp_im <= (r_cmd.kind == REQ_READ_AMP && !r_cmd.err) ?
                                        w_a_rdata[63:32] : '0;
                        r_ovalid <= 1'b1;
                        r_st <= S_IDLE;
                    end
                end
                default: r_st <= S_IDLE;
            endcase
        end
    end
endmodule

`default_nettype wire
